[hw/rtl/atpd_pkg.sv]
// Package for the accelerometer tap pulse detector: widths, register map, reset values, helpers.
`default_nettype none

package atpd_pkg;

  localparam int unsigned AxisWidth     = 14;
  localparam int unsigned MagWidth      = 15;
  localparam int unsigned LevelWidth    = 15;
  localparam int unsigned CountWidth    = 8;
  localparam int unsigned TotalWidth    = 32;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 15;

  typedef logic signed [AxisWidth-1:0] axis_t;
  typedef logic        [MagWidth-1:0]  mag_t;
  typedef logic        [LevelWidth-1:0] level_t;
  typedef logic        [CountWidth-1:0] count_t;
  typedef logic        [TotalWidth-1:0] total_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    RegPulseThreshold = 3'd0,
    RegQuietLevel     = 3'd1,
    RegMaxPulseWidth  = 3'd2,
    RegQuietRunNeeded = 3'd3,
    RegRearmLimit     = 3'd4
  } cfg_reg_e;

  localparam level_t PulseThresholdRst = 15'd2000;
  localparam level_t QuietLevelRst     = 15'd1200;
  localparam count_t MaxPulseWidthRst  = 8'd6;
  localparam count_t QuietRunNeededRst = 8'd10;
  localparam count_t RearmLimitRst     = 8'd100;

  // Magnitude of a two's complement axis sample; the most negative code maps to 2^13.
  function automatic logic [AxisWidth-1:0] abs_axis(axis_t v);
    logic [AxisWidth-1:0] u;
    u = v;
    return u[AxisWidth-1] ? (~u + {{(AxisWidth-1){1'b0}}, 1'b1}) : u;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/atpd_if.sv]
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none

interface atpd_sample_if;
  logic                 valid;
  logic                 ready;
  atpd_pkg::axis_t      accel_x;
  atpd_pkg::axis_t      accel_y;
  atpd_pkg::axis_t      accel_z;
  logic                 vibrating;
  logic                 batch_end;

  modport source (output valid, accel_x, accel_y, accel_z, vibrating, batch_end,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, vibrating, batch_end,
                  output ready);
endinterface

interface atpd_result_if;
  logic                 valid;
  logic                 ready;
  logic                 tap;
  atpd_pkg::mag_t       peak_jerk;
  atpd_pkg::total_t     tap_count;
  atpd_pkg::total_t     batch_count;

  modport source (output valid, tap, peak_jerk, tap_count, batch_count, input ready);
  modport sink   (input valid, tap, peak_jerk, tap_count, batch_count, output ready);
endinterface

interface atpd_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [atpd_pkg::CfgIndexWidth-1:0]     index;
  logic [atpd_pkg::CfgDataWidth-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/accel_tap_pulse_detector_top.sv]
// Top level of the accelerometer tap pulse detector.
//
// Samples enter on sample_i, one transaction per three-axis sample with its
// vibration and batch-end flags. Each sample yields exactly one transaction on
// result_o carrying the tap flag, the peak jerk and the tap and batch counts as
// they stand after that sample.
// Configuration is written through cfg_i (index, data); it is always ready and
// should only be written while no sample is in flight.
// A sample is captured in the input register; one pass of magnitude, jerk and
// decision logic then updates the state and loads the result register.
// Throughput is one sample per clock while the result receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; sample_i.ready drops only when both are full.
// Reset clears all state and counters, arms the detector and loads the
// default thresholds; no clearing pass is needed.
`default_nettype none

module accel_tap_pulse_detector_top (
  input  wire              clk_i,
  input  wire              rst_ni,
  atpd_sample_if.sink      sample_i,
  atpd_result_if.source    result_o,
  atpd_cfg_if.sink         cfg_i
);

  // Configuration registers.
  atpd_pkg::level_t pulse_threshold_q, quiet_level_q;
  atpd_pkg::count_t max_pulse_width_q, quiet_run_needed_q, rearm_limit_q;

  // Input register.
  logic             s1_valid_q, s1_valid_d;
  atpd_pkg::axis_t  s1_x_q, s1_y_q, s1_z_q;
  logic             s1_vib_q, s1_batch_q;

  // Detector state and result register.
  logic             res_valid_q, res_valid_d;
  logic             res_tap_q, res_tap_d;
  atpd_pkg::mag_t   prev_mag_q, prev_mag_d;
  logic             mag_valid_q, mag_valid_d;
  logic             armed_q, armed_d;
  atpd_pkg::count_t quiet_run_q, quiet_run_d;
  atpd_pkg::count_t disarmed_run_q, disarmed_run_d;
  logic             in_pulse_q, in_pulse_d;
  atpd_pkg::count_t pulse_width_q, pulse_width_d;
  atpd_pkg::mag_t   peak_q, peak_d;
  atpd_pkg::total_t tap_cnt_q, tap_cnt_d;
  atpd_pkg::total_t batch_cnt_q, batch_cnt_d;

  logic             s1_move, in_acc, cfg_acc;
  atpd_pkg::mag_t   mag, jerk;
  atpd_pkg::count_t quiet_run_inc, disarmed_run_inc, pulse_width_inc;
  logic             is_quiet;

  assign s1_move         = s1_valid_q && (!res_valid_q || result_o.ready);
  assign sample_i.ready  = !s1_valid_q || s1_move;
  assign in_acc          = sample_i.valid && sample_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign cfg_acc         = cfg_i.valid;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign res_valid_d = s1_move ? 1'b1 : (result_o.ready ? 1'b0 : res_valid_q);

  assign mag = atpd_pkg::MagWidth'(atpd_pkg::abs_axis(s1_x_q))
             + atpd_pkg::MagWidth'(atpd_pkg::abs_axis(s1_y_q))
             + atpd_pkg::MagWidth'(atpd_pkg::abs_axis(s1_z_q));
  assign jerk = (mag >= prev_mag_q) ? (mag - prev_mag_q) : (prev_mag_q - mag);
  assign is_quiet         = jerk < quiet_level_q;
  assign quiet_run_inc    = quiet_run_q + 8'd1;
  assign disarmed_run_inc = disarmed_run_q + 8'd1;
  assign pulse_width_inc  = pulse_width_q + 8'd1;

  always_comb begin
    prev_mag_d     = prev_mag_q;
    mag_valid_d    = mag_valid_q;
    armed_d        = armed_q;
    quiet_run_d    = quiet_run_q;
    disarmed_run_d = disarmed_run_q;
    in_pulse_d     = in_pulse_q;
    pulse_width_d  = pulse_width_q;
    peak_d         = peak_q;
    tap_cnt_d      = tap_cnt_q;
    batch_cnt_d    = batch_cnt_q;
    res_tap_d      = res_tap_q;

    if (s1_move) begin
      res_tap_d = 1'b0;
      priority if (s1_vib_q) begin
        mag_valid_d    = 1'b0;
        armed_d        = 1'b0;
        quiet_run_d    = '0;
        disarmed_run_d = '0;
        in_pulse_d     = 1'b0;
        pulse_width_d  = '0;
      end else if (!mag_valid_q) begin
        // First sample of a run only seeds the magnitude.
        prev_mag_d  = mag;
        mag_valid_d = 1'b1;
      end else begin
        prev_mag_d = mag;
        if (jerk > peak_q) begin
          peak_d = jerk;
        end
        priority if (!armed_q) begin
          if (is_quiet && (quiet_run_inc >= quiet_run_needed_q)) begin
            armed_d        = 1'b1;
            quiet_run_d    = '0;
            disarmed_run_d = '0;
          end else begin
            quiet_run_d = is_quiet ? quiet_run_inc : '0;
            if (disarmed_run_inc >= rearm_limit_q) begin
              armed_d        = 1'b1;
              quiet_run_d    = '0;
              disarmed_run_d = '0;
            end else begin
              disarmed_run_d = disarmed_run_inc;
            end
          end
        end else if (!in_pulse_q) begin
          if (jerk > pulse_threshold_q) begin
            in_pulse_d    = 1'b1;
            pulse_width_d = '0;
          end
        end else begin
          pulse_width_d = pulse_width_inc;
          priority if (is_quiet) begin
            in_pulse_d     = 1'b0;
            armed_d        = 1'b0;
            quiet_run_d    = '0;
            disarmed_run_d = '0;
            tap_cnt_d      = tap_cnt_q + 32'd1;
            res_tap_d      = 1'b1;
          end else if (pulse_width_inc >= max_pulse_width_q) begin
            // Too wide to be a tap: treat as motion and drop it.
            in_pulse_d = 1'b0;
          end else begin
            in_pulse_d = 1'b1;
          end
        end
      end
      if (s1_batch_q) begin
        batch_cnt_d = batch_cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_threshold_q  <= atpd_pkg::PulseThresholdRst;
      quiet_level_q      <= atpd_pkg::QuietLevelRst;
      max_pulse_width_q  <= atpd_pkg::MaxPulseWidthRst;
      quiet_run_needed_q <= atpd_pkg::QuietRunNeededRst;
      rearm_limit_q      <= atpd_pkg::RearmLimitRst;
    end else if (cfg_acc) begin
      unique case (atpd_pkg::cfg_reg_e'(cfg_i.index))
        atpd_pkg::RegPulseThreshold: pulse_threshold_q  <= cfg_i.data;
        atpd_pkg::RegQuietLevel:     quiet_level_q      <= cfg_i.data;
        atpd_pkg::RegMaxPulseWidth:  max_pulse_width_q  <= cfg_i.data[atpd_pkg::CountWidth-1:0];
        atpd_pkg::RegQuietRunNeeded: quiet_run_needed_q <= cfg_i.data[atpd_pkg::CountWidth-1:0];
        atpd_pkg::RegRearmLimit:     rearm_limit_q      <= cfg_i.data[atpd_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q     <= sample_i.accel_x;
      s1_y_q     <= sample_i.accel_y;
      s1_z_q     <= sample_i.accel_z;
      s1_vib_q   <= sample_i.vibrating;
      s1_batch_q <= sample_i.batch_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      res_valid_q    <= 1'b0;
      res_tap_q      <= 1'b0;
      prev_mag_q     <= '0;
      mag_valid_q    <= 1'b0;
      armed_q        <= 1'b1;
      quiet_run_q    <= '0;
      disarmed_run_q <= '0;
      in_pulse_q     <= 1'b0;
      pulse_width_q  <= '0;
      peak_q         <= '0;
      tap_cnt_q      <= '0;
      batch_cnt_q    <= '0;
    end else begin
      s1_valid_q     <= s1_valid_d;
      res_valid_q    <= res_valid_d;
      res_tap_q      <= res_tap_d;
      prev_mag_q     <= prev_mag_d;
      mag_valid_q    <= mag_valid_d;
      armed_q        <= armed_d;
      quiet_run_q    <= quiet_run_d;
      disarmed_run_q <= disarmed_run_d;
      in_pulse_q     <= in_pulse_d;
      pulse_width_q  <= pulse_width_d;
      peak_q         <= peak_d;
      tap_cnt_q      <= tap_cnt_d;
      batch_cnt_q    <= batch_cnt_d;
    end
  end

  // The state only moves when a result is loaded, so it always matches the held result.
  assign result_o.valid       = res_valid_q;
  assign result_o.tap         = res_tap_q;
  assign result_o.peak_jerk   = peak_q;
  assign result_o.tap_count   = tap_cnt_q;
  assign result_o.batch_count = batch_cnt_q;

`ifndef SYNTH
  a_tap_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_tap_q) |-> !armed_q)
    else $error("tap result held while detector is armed");

  a_pulse_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pulse_q |-> (armed_q && mag_valid_q))
    else $error("pulse open while disarmed or without a seeded magnitude");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && res_valid_q && !result_o.ready) |=> (s1_valid_q && $stable(tap_cnt_q)))
    else $error("input stage or state moved while result was stalled");
`endif

endmodule

`default_nettype wire

[tb/accel_tap_pulse_detector_top_tb.sv]
// Self-checking testbench for the accelerometer tap pulse detector top level.
`default_nettype none

module accel_tap_pulse_detector_top_tb;

  localparam int ResetCycles   = 11;
  localparam int SettleCycles  = 4;
  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 64;
  localparam int PhaseSamples  = 175;
  localparam logic [atpd_pkg::CfgIndexWidth-1:0] UnmappedReg = 3'd7;

  typedef struct {
    atpd_pkg::axis_t accel_x;
    atpd_pkg::axis_t accel_y;
    atpd_pkg::axis_t accel_z;
    logic            vibrating;
    logic            batch_end;
  } sample_t;

  typedef struct {
    logic             tap;
    atpd_pkg::mag_t   peak_jerk;
    atpd_pkg::total_t tap_count;
    atpd_pkg::total_t batch_count;
  } tap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  atpd_sample_if sample_ch ();
  atpd_result_if result_ch ();
  atpd_cfg_if    cfg_ch ();

  accel_tap_pulse_detector_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the detector configuration.
  atpd_pkg::level_t spike_level;
  atpd_pkg::level_t calm_level;
  atpd_pkg::count_t width_limit;
  atpd_pkg::count_t calm_run_goal;
  atpd_pkg::count_t rearm_after;

  // Mirror of the detector state.
  atpd_pkg::mag_t   last_mag;
  logic             mag_seeded;
  logic             is_armed;
  atpd_pkg::count_t calm_run;
  atpd_pkg::count_t idle_run;
  logic             pulse_open;
  atpd_pkg::count_t pulse_len;
  atpd_pkg::mag_t   jerk_peak;
  atpd_pkg::total_t taps_seen;
  atpd_pkg::total_t batches_seen;

  tap_result_t pending_results[$];
  int failures = 0;
  int samples_sent = 0;
  int send_gap_max = 0;
  int recv_stall_max = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int base_x = 0;
  int base_y = 0;
  int base_z = 0;

  function automatic atpd_pkg::mag_t axis_size(input atpd_pkg::axis_t v);
    int i;
    i = int'(v);
    return atpd_pkg::mag_t'((i < 0) ? -i : i);
  endfunction

  function automatic void rearm_detector();
    is_armed = 1'b1;
    calm_run = '0;
    idle_run = '0;
  endfunction

  // Advances the mirrored detector by one sample and returns its expected result.
  function automatic tap_result_t advance_detector(input sample_t s);
    tap_result_t    r;
    atpd_pkg::mag_t mag;
    atpd_pkg::mag_t jerk;
    r.tap = 1'b0;
    if (s.vibrating) begin
      mag_seeded = 1'b0;
      is_armed   = 1'b0;
      calm_run   = '0;
      idle_run   = '0;
      pulse_open = 1'b0;
      pulse_len  = '0;
    end else begin
      mag = axis_size(s.accel_x) + axis_size(s.accel_y) + axis_size(s.accel_z);
      if (!mag_seeded) begin
        last_mag   = mag;
        mag_seeded = 1'b1;
      end else begin
        jerk = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
        last_mag = mag;
        if (jerk > jerk_peak) begin
          jerk_peak = jerk;
        end
        if (!is_armed) begin
          if (jerk < calm_level) begin
            calm_run = calm_run + 8'd1;
            if (calm_run >= calm_run_goal) begin
              rearm_detector();
            end
          end else begin
            calm_run = '0;
          end
          if (!is_armed) begin
            idle_run = idle_run + 8'd1;
            if (idle_run >= rearm_after) begin
              rearm_detector();
            end
          end
        end else if (!pulse_open) begin
          if (jerk > spike_level) begin
            pulse_open = 1'b1;
            pulse_len  = '0;
          end
        end else begin
          pulse_len = pulse_len + 8'd1;
          if (jerk < calm_level) begin
            pulse_open = 1'b0;
            is_armed   = 1'b0;
            calm_run   = '0;
            idle_run   = '0;
            taps_seen  = taps_seen + 32'd1;
            r.tap      = 1'b1;
          end else if (pulse_len >= width_limit) begin
            pulse_open = 1'b0;
          end
        end
      end
    end
    if (s.batch_end) begin
      batches_seen = batches_seen + 32'd1;
    end
    r.peak_jerk   = jerk_peak;
    r.tap_count   = taps_seen;
    r.batch_count = batches_seen;
    return r;
  endfunction

  // Checks results, predicts accepted samples and mirrors register writes.
  always @(posedge clk_i) begin : track_traffic
    sample_t     s;
    tap_result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.tap !== want.tap) begin
          $display("%0t: tap expected %0d actual %0d", $time, want.tap, result_ch.tap);
          failures++;
        end
        if (result_ch.peak_jerk !== want.peak_jerk) begin
          $display("%0t: peak_jerk expected %0d actual %0d", $time, want.peak_jerk,
                   result_ch.peak_jerk);
          failures++;
        end
        if (result_ch.tap_count !== want.tap_count) begin
          $display("%0t: tap_count expected %0d actual %0d", $time, want.tap_count,
                   result_ch.tap_count);
          failures++;
        end
        if (result_ch.batch_count !== want.batch_count) begin
          $display("%0t: batch_count expected %0d actual %0d", $time, want.batch_count,
                   result_ch.batch_count);
          failures++;
        end
      end
    end
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      s.accel_x   = sample_ch.accel_x;
      s.accel_y   = sample_ch.accel_y;
      s.accel_z   = sample_ch.accel_z;
      s.vibrating = sample_ch.vibrating;
      s.batch_end = sample_ch.batch_end;
      pending_results.push_back(advance_detector(s));
    end
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        atpd_pkg::RegPulseThreshold: spike_level   = atpd_pkg::level_t'(cfg_ch.data);
        atpd_pkg::RegQuietLevel:     calm_level    = atpd_pkg::level_t'(cfg_ch.data);
        atpd_pkg::RegMaxPulseWidth:  width_limit   = atpd_pkg::count_t'(cfg_ch.data);
        atpd_pkg::RegQuietRunNeeded: calm_run_goal = atpd_pkg::count_t'(cfg_ch.data);
        atpd_pkg::RegRearmLimit:     rearm_after   = atpd_pkg::count_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls per transaction, or one long hold-off on request.
  initial begin : receive_results
    int stall;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        stall = (recv_stall_max > 0) ? $urandom_range(0, recv_stall_max) : 0;
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_ch.valid && result_ch.ready));
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.accel_x   <= s.accel_x;
    sample_ch.accel_y   <= s.accel_y;
    sample_ch.accel_z   <= s.accel_z;
    sample_ch.vibrating <= s.vibrating;
    sample_ch.batch_end <= s.batch_end;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
    samples_sent++;
  endtask

  task automatic send_axes(input atpd_pkg::axis_t x, input atpd_pkg::axis_t y,
                           input atpd_pkg::axis_t z, input logic vib, input logic bend);
    sample_t s;
    s.accel_x   = x;
    s.accel_y   = y;
    s.accel_z   = z;
    s.vibrating = vib;
    s.batch_end = bend;
    send_sample(s);
  endtask

  function automatic atpd_pkg::axis_t clamp_axis(input int v);
    if (v > 8191) begin
      v = 8191;
    end else if (v < -8192) begin
      v = -8192;
    end
    return atpd_pkg::axis_t'(v);
  endfunction

  function automatic atpd_pkg::axis_t rand_axis();
    return atpd_pkg::axis_t'($urandom_range(0, 16383));
  endfunction

  function automatic logic rand_batch();
    return ($urandom_range(0, 7) == 0);
  endfunction

  task automatic send_near_base(input int noise);
    send_axes(clamp_axis(base_x + int'($urandom_range(0, 2 * noise)) - noise),
              clamp_axis(base_y + int'($urandom_range(0, 2 * noise)) - noise),
              clamp_axis(base_z + int'($urandom_range(0, 2 * noise)) - noise),
              1'b0, rand_batch());
  endtask

  // Stops offering samples and lets every outstanding result drain.
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [atpd_pkg::CfgIndexWidth-1:0] index,
                                input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= atpd_pkg::CfgDataWidth'(value);
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int thr, input int quiet, input int width,
                               input int run_goal, input int limit);
    write_register(atpd_pkg::RegPulseThreshold, thr);
    write_register(atpd_pkg::RegQuietLevel, quiet);
    write_register(atpd_pkg::RegMaxPulseWidth, width);
    write_register(atpd_pkg::RegQuietRunNeeded, run_goal);
    write_register(atpd_pkg::RegRearmLimit, limit);
  endtask

  // Mostly tap-shaped bursts around a resting position, with noise and vibration mixed in.
  task automatic run_traffic(input int count);
    int stop;
    int kind;
    int noise;
    stop = samples_sent + count;
    while (samples_sent < stop) begin
      kind  = $urandom_range(0, 9);
      noise = (calm_level > 8000) ? 2000 : int'(calm_level) / 4;
      if (kind <= 5) begin
        repeat ($urandom_range(0, 3)) send_near_base(noise);
        send_axes(rand_axis(), rand_axis(), rand_axis(), 1'b0, rand_batch());
        repeat ($urandom_range(0, 3)) send_axes(rand_axis(), rand_axis(), rand_axis(),
                                                1'b0, rand_batch());
        repeat ($urandom_range(2, 12)) send_near_base(noise);
      end else if (kind == 6) begin
        repeat ($urandom_range(1, 6)) send_axes(rand_axis(), rand_axis(), rand_axis(),
                                                ($urandom_range(0, 3) == 0), rand_batch());
      end else if (kind == 7) begin
        send_axes(rand_axis(), rand_axis(), rand_axis(), 1'b1, rand_batch());
        send_near_base(noise);
      end else if (kind == 8) begin
        repeat ($urandom_range(5, 40)) send_near_base(noise);
      end else begin
        base_x = int'($urandom_range(0, 8000)) - 4000;
        base_y = int'($urandom_range(0, 8000)) - 4000;
        base_z = int'($urandom_range(0, 8000)) - 4000;
      end
    end
  endtask

  task automatic test_tap_shape();
    send_axes(clamp_axis(8191), clamp_axis(-8192), clamp_axis(0), 1'b0, 1'b0);
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b1);
    send_axes(clamp_axis(1), clamp_axis(-1), clamp_axis(0), 1'b0, 1'b0);
  endtask

  // The sample after vibration only seeds; the full-scale swing then sets the peak.
  task automatic test_vibration();
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b1, 1'b1);
    send_axes(clamp_axis(-8192), clamp_axis(-8192), clamp_axis(-8192), 1'b0, 1'b0);
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
  endtask

  task automatic test_rearm_and_motion();
    wait_idle();
    write_register(atpd_pkg::RegQuietRunNeeded, 1);
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    send_axes(clamp_axis(3000), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    repeat (3) begin
      send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
      send_axes(clamp_axis(3000), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    end
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b1);
  endtask

  // Zero counts and thresholds, then all-ones values, an aliased width and an unmapped index.
  task automatic test_register_limits();
    wait_idle();
    apply_setting(0, 0, 'h100, 0, 0);
    send_axes(clamp_axis(100), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    send_axes(clamp_axis(200), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    send_axes(clamp_axis(0), clamp_axis(0), clamp_axis(0), 1'b0, 1'b0);
    wait_idle();
    apply_setting('h7FFF, 'h7FFF, 'h7FFF, 'hFF, 'hFF);
    write_register(UnmappedReg, 'h1234);
    send_axes(clamp_axis(8191), clamp_axis(8191), clamp_axis(8191), 1'b0, 1'b1);
    send_axes(clamp_axis(-8192), clamp_axis(-8192), clamp_axis(-8192), 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          apply_setting(2000, 1200, 6, 10, 100);
          send_gap_max   = 15;
          recv_stall_max = 15;
        end
        1: begin
          apply_setting(500, 400, 3, 4, 20);
          send_gap_max   = 0;
          recv_stall_max = 0;
        end
        2: begin
          apply_setting(300, 6000, 1, 1, 1);
          send_gap_max   = 15;
          recv_stall_max = 0;
        end
        3: begin
          apply_setting(24576, 24576, 255, 255, 255);
          send_gap_max   = 0;
          recv_stall_max = 15;
        end
        4: begin
          apply_setting($urandom_range(0, 8000), $urandom_range(0, 6000),
                        $urandom_range(1, 20), $urandom_range(1, 40),
                        $urandom_range(1, 255));
          send_gap_max   = 15;
          recv_stall_max = 15;
        end
        default: begin
          apply_setting(0, 24576, 0, 0, 0);
          send_gap_max   = 15;
          recv_stall_max = 15;
        end
      endcase
      run_traffic(PhaseSamples);
    end
  endtask

  // The receiver holds off long enough for the input side to back up.
  task automatic test_backpressure();
    wait_idle();
    apply_setting(2000, 1200, 6, 10, 100);
    send_gap_max   = 0;
    recv_stall_max = 0;
    hold_cycles    = HoldOffCycles;
    run_traffic(40);
  endtask

  initial begin
    rst_ni              = 1'b0;
    sample_ch.valid     = 1'b0;
    sample_ch.accel_x   = '0;
    sample_ch.accel_y   = '0;
    sample_ch.accel_z   = '0;
    sample_ch.vibrating = 1'b0;
    sample_ch.batch_end = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = atpd_pkg::RegPulseThreshold;
    cfg_ch.data         = '0;

    spike_level   = atpd_pkg::PulseThresholdRst;
    calm_level    = atpd_pkg::QuietLevelRst;
    width_limit   = atpd_pkg::MaxPulseWidthRst;
    calm_run_goal = atpd_pkg::QuietRunNeededRst;
    rearm_after   = atpd_pkg::RearmLimitRst;
    last_mag      = '0;
    mag_seeded    = 1'b0;
    is_armed      = 1'b1;
    calm_run      = '0;
    idle_run      = '0;
    pulse_open    = 1'b0;
    pulse_len     = '0;
    jerk_peak     = '0;
    taps_seen     = '0;
    batches_seen  = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tap_shape();
    test_vibration();
    test_rearm_and_motion();
    test_register_limits();
    test_random_traffic();
    test_backpressure();
    wait_idle();

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/atpd_pkg.sv
hw/rtl/atpd_if.sv
hw/rtl/accel_tap_pulse_detector_top.sv
tb/accel_tap_pulse_detector_top_tb.sv
